// File: hw/rtl/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg
// Shared widths, register map, reset values and types of the fixed-gain
// three-state tracker.
// ----------------------------------------------------------------------------
package kft_pkg;

  // field widths
  localparam int SAMPLE_W    = 32;
  localparam int OUT_W       = 32;
  localparam int DT_W        = 24;
  localparam int GAIN_W      = 16;
  localparam int DT_FRAC     = 24;
  localparam int GAIN_FRAC   = 16;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_TIME     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_BIAS     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_VELOCITY = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_POSITION = 8'd3;

  localparam logic [DT_W-1:0]   STEP_TIME_RESET     = 24'd16777;
  localparam logic [GAIN_W-1:0] GAIN_BIAS_RESET     = 16'd3277;
  localparam logic [GAIN_W-1:0] GAIN_VELOCITY_RESET = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN_POSITION_RESET = 16'd16384;

  // item kinds carried in tuser
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam int DATA_WIDTH_DEFAULT = 32;

  // datapath widths: exact sums, exact products, rounded terms, final add
  localparam int SUM_W       = SAMPLE_W + 1;
  localparam int DT_PROD_W   = DT_W + 1 + SUM_W;
  localparam int GAIN_PROD_W = GAIN_W + 1 + SUM_W;
  localparam int TERM_W      = SUM_W + 1;
  localparam int ACC_W       = TERM_W + 1;

  typedef struct packed {
    logic [DT_W-1:0]   step_time;
    logic [GAIN_W-1:0] gain_bias;
    logic [GAIN_W-1:0] gain_velocity;
    logic [GAIN_W-1:0] gain_position;
  } kft_cfg_t;

  // round to nearest, ties toward plus infinity, then drop DT_FRAC bits
  function automatic logic signed [TERM_W-1:0] round_dt(
    input logic signed [DT_PROD_W-1:0] p
  );
    logic signed [DT_PROD_W-1:0] biased;
    biased = p + (DT_PROD_W'(1) <<< (DT_FRAC - 1));
    return TERM_W'(biased >>> DT_FRAC);
  endfunction

  function automatic logic signed [TERM_W-1:0] round_gain(
    input logic signed [GAIN_PROD_W-1:0] p
  );
    logic signed [GAIN_PROD_W-1:0] biased;
    biased = p + (GAIN_PROD_W'(1) <<< (GAIN_FRAC - 1));
    return TERM_W'(biased >>> GAIN_FRAC);
  endfunction

endpackage

// File: hw/rtl/kft_core.sv
// ----------------------------------------------------------------------------
// kft_core
// Estimate registers and the combinational predict / update datapath.
// ----------------------------------------------------------------------------
module kft_core #(
  parameter int DATA_WIDTH = kft_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                op,
  input  logic signed [kft_pkg::SAMPLE_W-1:0] sample,
  input  kft_pkg::kft_cfg_t                   cfg,
  output logic signed [kft_pkg::OUT_W-1:0]    bias,
  output logic signed [kft_pkg::OUT_W-1:0]    velocity,
  output logic signed [kft_pkg::OUT_W-1:0]    position
);
  import kft_pkg::*;

  localparam int EST_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam logic signed [ACC_W-1:0] EST_MAX = ACC_W'((64'sd1 <<< (EST_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] EST_MIN = -EST_MAX - ACC_W'(1);

  logic signed [EST_W-1:0] bias_est;
  logic signed [EST_W-1:0] velocity_est;
  logic signed [EST_W-1:0] position_est;
  logic signed [EST_W-1:0] bias_next;
  logic signed [EST_W-1:0] velocity_next;
  logic signed [EST_W-1:0] position_next;

  logic signed [SUM_W-1:0]       accel_sum;
  logic signed [SUM_W-1:0]       innov;
  logic signed [DT_W:0]          dt_s;
  logic signed [GAIN_W:0]        gb_s;
  logic signed [GAIN_W:0]        gv_s;
  logic signed [GAIN_W:0]        gp_s;
  logic signed [DT_PROD_W-1:0]   dv_prod;
  logic signed [DT_PROD_W-1:0]   dp_prod;
  logic signed [GAIN_PROD_W-1:0] cb_prod;
  logic signed [GAIN_PROD_W-1:0] cv_prod;
  logic signed [GAIN_PROD_W-1:0] cp_prod;
  logic signed [TERM_W-1:0]      bias_term;
  logic signed [TERM_W-1:0]      velocity_term;
  logic signed [TERM_W-1:0]      position_term;

  function automatic logic signed [EST_W-1:0] sat_add(
    input logic signed [EST_W-1:0]  est,
    input logic signed [TERM_W-1:0] term
  );
    logic signed [ACC_W-1:0] acc;
    acc = ACC_W'(est) + ACC_W'(term);
    if (acc > EST_MAX) begin
      acc = EST_MAX;
    end else if (acc < EST_MIN) begin
      acc = EST_MIN;
    end
    return EST_W'(acc);
  endfunction

  always_comb begin
    dt_s      = $signed({1'b0, cfg.step_time});
    gb_s      = $signed({1'b0, cfg.gain_bias});
    gv_s      = $signed({1'b0, cfg.gain_velocity});
    gp_s      = $signed({1'b0, cfg.gain_position});
    accel_sum = SUM_W'(bias_est) + SUM_W'(sample);
    innov     = SUM_W'(sample) - SUM_W'(position_est);
    dv_prod   = DT_PROD_W'(dt_s) * DT_PROD_W'(accel_sum);
    dp_prod   = DT_PROD_W'(dt_s) * DT_PROD_W'(velocity_est);
    cb_prod   = GAIN_PROD_W'(gb_s) * GAIN_PROD_W'(innov);
    cv_prod   = GAIN_PROD_W'(gv_s) * GAIN_PROD_W'(innov);
    cp_prod   = GAIN_PROD_W'(gp_s) * GAIN_PROD_W'(innov);

    if (op == OP_UPDATE) begin
      bias_term     = round_gain(cb_prod);
      velocity_term = round_gain(cv_prod);
      position_term = round_gain(cp_prod);
    end else begin
      // predict leaves bias alone; position moves by the old velocity
      bias_term     = '0;
      velocity_term = round_dt(dv_prod);
      position_term = round_dt(dp_prod);
    end

    bias_next     = sat_add(bias_est, bias_term);
    velocity_next = sat_add(velocity_est, velocity_term);
    position_next = sat_add(position_est, position_term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_est     <= '0;
      velocity_est <= '0;
      position_est <= '0;
    end else if (step) begin
      bias_est     <= bias_next;
      velocity_est <= velocity_next;
      position_est <= position_next;
    end
  end

  assign bias     = OUT_W'(bias_est);
  assign velocity = OUT_W'(velocity_est);
  assign position = OUT_W'(position_est);

endmodule

// File: hw/rtl/fixed_gain_kalman_tracker.sv
// ----------------------------------------------------------------------------
// fixed_gain_kalman_tracker
// Fixed-gain three-state (bias, velocity, position) tracker, signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while results are taken and offers its
// result on the master side after an input register, then the estimate
// registers, which also serve as the result register. Throughput is one item
// per cycle whenever the output side keeps taking results; a held result
// stalls the input once the input register is full too. The clock is set by
// the estimate feedback path: a 33-bit pre-add, one 25x33 or 17x33 multiply,
// a rounding add and a saturating add in one combinational path. tuser selects predict
// (0, tdata is the acceleration) or update (1, tdata is the measured
// position). Each result carries the new bias, velocity and position
// estimates. Configuration writes are always taken and should be made while
// no request is in flight.
module fixed_gain_kalman_tracker #(
  parameter int DATA_WIDTH = kft_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [kft_pkg::SAMPLE_W-1:0]         s_tdata,   // [31:0] sample_value
  input  logic                                 s_tuser,   // [0] op
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [3*kft_pkg::OUT_W-1:0]          m_tdata,   // bias_out, velocity_out,
                                                          // position_out
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [kft_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [kft_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kft_pkg::*;

  kft_cfg_t cfg;

  logic                       in_valid;
  logic                       in_op;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       advance;
  logic                       step;

  logic signed [OUT_W-1:0] bias;
  logic signed [OUT_W-1:0] velocity;
  logic signed [OUT_W-1:0] position;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_time     <= STEP_TIME_RESET;
      cfg.gain_bias     <= GAIN_BIAS_RESET;
      cfg.gain_velocity <= GAIN_VELOCITY_RESET;
      cfg.gain_position <= GAIN_POSITION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STEP_TIME:     cfg.step_time     <= cfg_data[DT_W-1:0];
        REG_GAIN_BIAS:     cfg.gain_bias     <= cfg_data[GAIN_W-1:0];
        REG_GAIN_VELOCITY: cfg.gain_velocity <= cfg_data[GAIN_W-1:0];
        REG_GAIN_POSITION: cfg.gain_position <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // the result register frees up when empty or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op     <= s_tuser;
      in_sample <= $signed(s_tdata);
    end
  end

  kft_core #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .op       (in_op),
    .sample   (in_sample),
    .cfg      (cfg),
    .bias     (bias),
    .velocity (velocity),
    .position (position)
  );

  assign m_tdata = {position, velocity, bias};

  // estimates come out of reset cleared and no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (m_tdata == '0 && !m_tvalid && !in_valid))
    else $error("estimates or valids not cleared by reset");

  // estimates move only when an item goes through
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(m_tdata))
    else $error("estimates changed without an item");

  // predict never touches the bias estimate
  a_predict_bias: assert property (@(posedge clk) disable iff (rst)
    (step && in_op == OP_PREDICT) |=> $stable(m_tdata[OUT_W-1:0]))
    else $error("bias changed on predict");

  // a held input item is not lost while the output stalls
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_sample) && $stable(in_op)))
    else $error("stalled input item lost");

endmodule

// File: verif/kalman_track_checker.sv
// ----------------------------------------------------------------------------
// kalman_track_checker
// Watches the request, result and register write channels of the tracker,
// keeps its own bias, velocity and position estimates, and compares every
// result with the oldest estimate triple still due.
// ----------------------------------------------------------------------------
module kalman_track_checker #(
  parameter int DATA_WIDTH = kft_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [kft_pkg::SAMPLE_W-1:0]     s_tdata,    // [31:0] sample_value
  input  logic                             s_tuser,    // [0] op
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [3*kft_pkg::OUT_W-1:0]      m_tdata,    // bias_out, velocity_out,
                                                       // position_out
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [kft_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kft_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               errors,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import kft_pkg::*;

  localparam int EST_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
  localparam longint EST_MAX = (longint'(1) <<< (EST_W - 1)) - 1;
  localparam longint EST_MIN = -EST_MAX - 1;

  // bias sits in the lowest bits of tdata
  typedef struct packed {
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] velocity;
    logic [OUT_W-1:0] bias;
  } estimates_t;

  kft_cfg_t   filter_cfg;
  longint     bias_est;
  longint     velocity_est;
  longint     position_est;
  estimates_t estimates_due[$];

  // add half an lsb, then floor
  function automatic longint round_drop(longint v, int frac);
    return (v + (longint'(1) <<< (frac - 1))) >>> frac;
  endfunction

  function automatic longint clamp_est(longint v);
    if (v > EST_MAX) return EST_MAX;
    if (v < EST_MIN) return EST_MIN;
    return v;
  endfunction

  function automatic estimates_t advance_estimates(logic op, logic [SAMPLE_W-1:0] sample);
    longint     s;
    longint     y;
    longint     dv;
    longint     dp;
    estimates_t next;
    s = longint'($signed(sample));
    if (op == OP_PREDICT) begin
      // both terms use the old estimates
      dv = round_drop(longint'(filter_cfg.step_time) * (bias_est + s), DT_FRAC);
      dp = round_drop(longint'(filter_cfg.step_time) * velocity_est, DT_FRAC);
      velocity_est = clamp_est(velocity_est + dv);
      position_est = clamp_est(position_est + dp);
    end else begin
      y = s - position_est;
      bias_est = clamp_est(bias_est +
                           round_drop(longint'(filter_cfg.gain_bias) * y, GAIN_FRAC));
      velocity_est = clamp_est(velocity_est +
                               round_drop(longint'(filter_cfg.gain_velocity) * y, GAIN_FRAC));
      position_est = clamp_est(position_est +
                               round_drop(longint'(filter_cfg.gain_position) * y, GAIN_FRAC));
    end
    next.bias     = bias_est[OUT_W-1:0];
    next.velocity = velocity_est[OUT_W-1:0];
    next.position = position_est[OUT_W-1:0];
    return next;
  endfunction

  task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    estimates_t want;
    estimates_t got;
    if (rst) begin
      filter_cfg.step_time     = STEP_TIME_RESET;
      filter_cfg.gain_bias     = GAIN_BIAS_RESET;
      filter_cfg.gain_velocity = GAIN_VELOCITY_RESET;
      filter_cfg.gain_position = GAIN_POSITION_RESET;
      bias_est     = 0;
      velocity_est = 0;
      position_est = 0;
      estimates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_TIME:     filter_cfg.step_time     = cfg_data[DT_W-1:0];
          REG_GAIN_BIAS:     filter_cfg.gain_bias     = cfg_data[GAIN_W-1:0];
          REG_GAIN_VELOCITY: filter_cfg.gain_velocity = cfg_data[GAIN_W-1:0];
          REG_GAIN_POSITION: filter_cfg.gain_position = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      // a result leaving now belongs to an older request, so pop first
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (estimates_due.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = estimates_due.pop_front();
          check_field("bias_out", want.bias, got.bias);
          check_field("velocity_out", want.velocity, got.velocity);
          check_field("position_out", want.position, got.position);
        end
      end
      if (s_tvalid && s_tready)
        estimates_due.push_back(advance_estimates(s_tuser, s_tdata));
    end
    pending <= estimates_due.size();
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the fixed-gain tracker: a short directed run over the field
// extremes, zero and full-scale gains and rounding ties, then random phases
// with changing register settings, random gaps on both streams and one long
// result back-pressure. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kft_pkg::*;

  localparam int DATA_WIDTH    = DATA_WIDTH_DEFAULT;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 190;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 8'd4;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata = '0;
  logic                   s_tuser = OP_PREDICT;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [3*OUT_W-1:0]     m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     errors;
  int                     pending;
  bit                     hold_off = 1'b0;

  fixed_gain_kalman_tracker #(.DATA_WIDTH(DATA_WIDTH)) DUT (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  kalman_track_checker #(.DATA_WIDTH(DATA_WIDTH)) track_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic pick_op();
    return ($urandom_range(0, 99) < 55) ? OP_PREDICT : OP_UPDATE;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] raw;
    int r;
    raw = $urandom;
    r = $urandom_range(0, 99);
    if (r < 35) return {{11{raw[20]}}, raw[20:0]};
    if (r < 60) return {{5{raw[26]}}, raw[26:0]};
    if (r < 88) return raw;
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // result side: runs of ready, random stalls, one long hold on request
  initial begin : result_sink
    int run;
    int gap;
    forever begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
        m_tready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // leaves valid high; the caller lowers it or offers the next request
  task automatic offer(logic op, logic [SAMPLE_W-1:0] value);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic feed(logic op, logic [SAMPLE_W-1:0] value);
    offer(op, value);
    pause_sender(pick_gap());
  endtask

  // pending is registered, so always step before looking at it
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(logic [CFG_DATA_W-1:0] dt, logic [CFG_DATA_W-1:0] gb,
                               logic [CFG_DATA_W-1:0] gv, logic [CFG_DATA_W-1:0] gp);
    drain();
    // unmapped index must leave every register alone
    write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, 255)), $urandom);
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_GAIN_BIAS, gb);
    write_reg(REG_GAIN_VELOCITY, gv);
    write_reg(REG_GAIN_POSITION, gp);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int count, bit steady, bit press);
    int n;
    int gap;
    if (press) hold_off = 1'b1;
    for (n = 0; n < count; n++) begin
      offer(pick_op(), pick_sample());
      if ((press && hold_off) || (steady && n >= count / 2))
        gap = 0;
      else
        gap = pick_gap();
      pause_sender(gap);
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin : stimulus
    int p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    feed(OP_PREDICT, 32'h0000_0000);
    feed(OP_PREDICT, 32'h7FFF_FFFF);
    feed(OP_PREDICT, 32'h8000_0000);
    feed(OP_UPDATE,  32'h7FFF_FFFF);
    feed(OP_UPDATE,  32'h8000_0000);
    feed(OP_UPDATE,  32'h0000_0000);
    feed(OP_PREDICT, 32'hFFFF_FFFF);
    feed(OP_UPDATE,  32'h0000_0001);

    // full-scale dt and gains drive every estimate into saturation
    load_settings(32'h00FF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    feed(OP_UPDATE,  32'h7FFF_FFFF);
    feed(OP_UPDATE,  32'h7FFF_FFFF);
    feed(OP_PREDICT, 32'h7FFF_FFFF);
    feed(OP_PREDICT, 32'h7FFF_FFFF);
    feed(OP_UPDATE,  32'h8000_0000);
    feed(OP_UPDATE,  32'h8000_0000);
    feed(OP_PREDICT, 32'h8000_0000);
    feed(OP_PREDICT, 32'h8000_0000);

    // zero dt and gains, written with junk above the register width
    load_settings(32'hFF00_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
    feed(OP_PREDICT, 32'h7FFF_FFFF);
    feed(OP_UPDATE,  32'h8000_0000);
    feed(OP_PREDICT, 32'h0000_0001);
    feed(OP_UPDATE,  32'hFFFF_FFFF);

    // half-scale factors give exact ties in rounding
    load_settings(32'h0080_0000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    feed(OP_PREDICT, 32'h0000_0001);
    feed(OP_UPDATE,  32'hFFFF_FFFD);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(CFG_DATA_W'(STEP_TIME_RESET), CFG_DATA_W'(GAIN_BIAS_RESET),
                         CFG_DATA_W'(GAIN_VELOCITY_RESET), CFG_DATA_W'(GAIN_POSITION_RESET));
        1: load_settings(32'h00FF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
        2: load_settings(32'h0000_0000, $urandom, $urandom, $urandom);
        3: load_settings($urandom, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        4: load_settings($urandom_range(0, 65535), 32'h0000_FFFF, 32'h0000_FFFF,
                         32'h0000_FFFF);
        default: load_settings($urandom, $urandom, $urandom, $urandom);
      endcase
      run_phase(PHASE_ITEMS, p == 5, p == 3);
    end

    drain();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
